>>> sv/sprg_pkg.sv
// package: types, codes and reset values for the servo pulse ramp generator
`timescale 1ns / 1ps

package sprg_pkg;

	localparam int PULSE_W = 16;
	localparam int SERVOS = 4;
	localparam int SPRG_STEP = 16;

	localparam logic [PULSE_W-1:0] RST_PULSE = 16'd1500;
	localparam logic [PULSE_W-1:0] RST_MIN = 16'd1000;
	localparam logic [PULSE_W-1:0] RST_MAX = 16'd2000;

	typedef enum logic [1:0] {
		ST_STEP = 2'd0,
		ST_FINAL = 2'd1,
		ST_ABORT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SG_NONE = 2'd0,
		SG_UP = 2'd1,
		SG_DOWN = 2'd3
	} sign_t;

	typedef enum logic [2:0] {
		REG_MIN_S0 = 3'd0,
		REG_MAX_S0 = 3'd1,
		REG_MIN_S1 = 3'd2,
		REG_MAX_S1 = 3'd3,
		REG_MIN_S2 = 3'd4,
		REG_MAX_S2 = 3'd5,
		REG_MIN_S3 = 3'd6,
		REG_MAX_S3 = 3'd7
	} reg_idx_t;

	localparam int OP_TARGET = 0;
	localparam int OP_TICK = 1;

endpackage

>>> sv/servo_pulse_ramp_generator_core.sv
// Servo pulse ramp generator: a target request captures the applied pulses and sets up
// a ramp; every tick then moves each moving servo by STEP, checked against the min/max
// limits, until the final tick applies the targets or a breach aborts. Every request is
// handled in the cycle it is accepted and its result lands in the output register, so
// one request is taken per cycle; in_ready drops only while a result is held and
// out_ready is low. Target requests and ticks without a ramp give no result. Limits must
// be written through cfg_we/cfg_addr/cfg_wdata only while the block is idle; unenforced.
`timescale 1ns / 1ps

module servo_pulse_ramp_generator_core #(
	parameter int STEP = sprg_pkg::SPRG_STEP
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_addr,
	input  logic [sprg_pkg::PULSE_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [sprg_pkg::PULSE_W-1:0]  target_s0,
	input  logic [sprg_pkg::PULSE_W-1:0]  target_s1,
	input  logic [sprg_pkg::PULSE_W-1:0]  target_s2,
	input  logic [sprg_pkg::PULSE_W-1:0]  target_s3,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sprg_pkg::PULSE_W-1:0]  pulse_s0,
	output logic [sprg_pkg::PULSE_W-1:0]  pulse_s1,
	output logic [sprg_pkg::PULSE_W-1:0]  pulse_s2,
	output logic [sprg_pkg::PULSE_W-1:0]  pulse_s3,
	output logic [1:0]                    status
);
	import sprg_pkg::*;

	localparam int OFF_W = PULSE_W + $clog2(STEP + 1);
	localparam int PW = OFF_W + 2;

	logic [PULSE_W-1:0] min_q [SERVOS];
	logic [PULSE_W-1:0] max_q [SERVOS];
	logic [PULSE_W-1:0] applied_q [SERVOS];
	logic [PULSE_W-1:0] base_q [SERVOS];
	logic [PULSE_W-1:0] goal_q [SERVOS];
	sign_t              sign_q [SERVOS];
	logic [PULSE_W-1:0] mag_q;
	logic [OFF_W-1:0]   off_q;
	logic               active_q;

	logic               out_valid_q;
	logic [PULSE_W-1:0] res_pulse_q [SERVOS];
	status_t            status_q;

	logic [PULSE_W-1:0] tgt [SERVOS];
	logic signed [PW-1:0] step_p [SERVOS];
	logic [SERVOS-1:0]  bad;
	logic [PULSE_W-1:0] nxt_applied [SERVOS];
	logic [PULSE_W-1:0] nxt_mag;
	logic               take;
	logic               is_tgt;
	logic               produce;
	logic               at_final;
	logic               any_bad;
	status_t            nxt_status;

	assign tgt[0] = target_s0;
	assign tgt[1] = target_s1;
	assign tgt[2] = target_s2;
	assign tgt[3] = target_s3;

	assign in_ready = !out_valid_q || out_ready;
	assign take = in_valid && in_ready;
	assign is_tgt = take && (op == 1'(OP_TARGET));
	assign produce = take && (op == 1'(OP_TICK)) && active_q;

	// final tick once j*STEP + STEP exceeds the highest-numbered moving servo's distance
	assign at_final = (({1'b0, off_q} + (OFF_W+1)'(STEP)) > (OFF_W+1)'(mag_q));

	always_comb begin
		for (int i = 0; i < SERVOS; i++) begin
			case (sign_q[i])
				SG_UP: step_p[i] = $signed(PW'(base_q[i])) + $signed(PW'(off_q));
				SG_DOWN: step_p[i] = $signed(PW'(base_q[i])) - $signed(PW'(off_q));
				default: step_p[i] = $signed(PW'(base_q[i]));
			endcase
			bad[i] = (step_p[i] < $signed(PW'(min_q[i]))) ||
				(step_p[i] > $signed(PW'(max_q[i])));
		end
	end

	assign any_bad = |bad;

	always_comb begin
		nxt_status = ST_STEP;
		for (int i = 0; i < SERVOS; i++) begin
			nxt_applied[i] = applied_q[i];
		end
		if (at_final) begin
			nxt_status = ST_FINAL;
			for (int i = 0; i < SERVOS; i++) begin
				if (sign_q[i] != SG_NONE) begin
					nxt_applied[i] = goal_q[i];
				end
			end
		end else if (any_bad) begin
			nxt_status = ST_ABORT;
		end else begin
			for (int i = 0; i < SERVOS; i++) begin
				nxt_applied[i] = step_p[i][PULSE_W-1:0];
			end
		end
	end

	// ramp length follows the highest-numbered servo that moves
	always_comb begin
		nxt_mag = '0;
		for (int i = 0; i < SERVOS; i++) begin
			if (tgt[i] > applied_q[i]) begin
				nxt_mag = tgt[i] - applied_q[i];
			end else if (tgt[i] < applied_q[i]) begin
				nxt_mag = applied_q[i] - tgt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SERVOS; i++) begin
				min_q[i] <= RST_MIN;
				max_q[i] <= RST_MAX;
			end
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN_S0: min_q[0] <= cfg_wdata;
				REG_MAX_S0: max_q[0] <= cfg_wdata;
				REG_MIN_S1: min_q[1] <= cfg_wdata;
				REG_MAX_S1: max_q[1] <= cfg_wdata;
				REG_MIN_S2: min_q[2] <= cfg_wdata;
				REG_MAX_S2: max_q[2] <= cfg_wdata;
				REG_MIN_S3: min_q[3] <= cfg_wdata;
				REG_MAX_S3: max_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SERVOS; i++) begin
				applied_q[i] <= RST_PULSE;
				base_q[i] <= '0;
				goal_q[i] <= '0;
				sign_q[i] <= SG_NONE;
			end
			mag_q <= '0;
			off_q <= '0;
			active_q <= 1'b0;
		end else if (is_tgt) begin
			for (int i = 0; i < SERVOS; i++) begin
				base_q[i] <= applied_q[i];
				goal_q[i] <= tgt[i];
				if (tgt[i] > applied_q[i]) begin
					sign_q[i] <= SG_UP;
				end else if (tgt[i] < applied_q[i]) begin
					sign_q[i] <= SG_DOWN;
				end else begin
					sign_q[i] <= SG_NONE;
				end
			end
			mag_q <= nxt_mag;
			off_q <= '0;
			active_q <= 1'b1;
		end else if (produce) begin
			for (int i = 0; i < SERVOS; i++) begin
				applied_q[i] <= nxt_applied[i];
			end
			if (at_final || any_bad) begin
				active_q <= 1'b0;
			end else begin
				off_q <= off_q + OFF_W'(STEP);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			for (int i = 0; i < SERVOS; i++) begin
				res_pulse_q[i] <= nxt_applied[i];
			end
			status_q <= nxt_status;
		end
	end

	assign out_valid = out_valid_q;
	assign pulse_s0 = res_pulse_q[0];
	assign pulse_s1 = res_pulse_q[1];
	assign pulse_s2 = res_pulse_q[2];
	assign pulse_s3 = res_pulse_q[3];
	assign status = status_q;

`ifndef SYNTHESIS
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid_q && !out_ready))
		else $error("in_ready low without a stalled result");

	a_target_arms: assert property (@(posedge clk) disable iff (!arst_n)
		is_tgt |=> (active_q && (off_q == '0)))
		else $error("target request did not start a ramp");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		produce |=> out_valid_q)
		else $error("tick on active ramp gave no result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == ST_STEP || status_q == ST_FINAL ||
			status_q == ST_ABORT))
		else $error("result carries an unknown status");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && (at_final || any_bad)) |=> !active_q)
		else $error("ramp still active after final or abort");
`endif

endmodule

>>> test/servo_pulse_ramp_generator_core_check.sv
// checker for the servo pulse ramp generator: predicts every result and compares it
`timescale 1ns / 1ps

module servo_pulse_ramp_generator_core_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_addr,
	input  logic [sprg_pkg::PULSE_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          op,
	input  logic [sprg_pkg::PULSE_W-1:0]  target_s0,
	input  logic [sprg_pkg::PULSE_W-1:0]  target_s1,
	input  logic [sprg_pkg::PULSE_W-1:0]  target_s2,
	input  logic [sprg_pkg::PULSE_W-1:0]  target_s3,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [sprg_pkg::PULSE_W-1:0]  pulse_s0,
	input  logic [sprg_pkg::PULSE_W-1:0]  pulse_s1,
	input  logic [sprg_pkg::PULSE_W-1:0]  pulse_s2,
	input  logic [sprg_pkg::PULSE_W-1:0]  pulse_s3,
	input  logic [1:0]                    status,
	output int                            mismatches,
	output int                            pending
);
	import sprg_pkg::*;

	typedef struct packed {
		logic [SERVOS-1:0][PULSE_W-1:0] pulse;
		status_t                        status;
	} pulse_set_t;

	pulse_set_t         due_pulses [$];
	logic [PULSE_W-1:0] lim_lo [SERVOS];
	logic [PULSE_W-1:0] lim_hi [SERVOS];
	logic [PULSE_W-1:0] applied [SERVOS];
	logic [PULSE_W-1:0] base [SERVOS];
	logic [PULSE_W-1:0] goal [SERVOS];
	sign_t              dir [SERVOS];
	logic [PULSE_W-1:0] ramp_len;
	logic [PULSE_W-1:0] step_no;
	logic               running;

	function automatic pulse_set_t applied_set(input status_t st);
		pulse_set_t s;
		for (int i = 0; i < SERVOS; i++)
			s.pulse[i] = applied[i];
		s.status = st;
		return s;
	endfunction

	task automatic follow_request(input logic is_tick,
			input logic [SERVOS-1:0][PULSE_W-1:0] tgt);
		int     diff;
		longint next [SERVOS];
		logic   out_of_range;
		if (!is_tick) begin
			ramp_len = '0;
			for (int i = 0; i < SERVOS; i++) begin
				diff = int'(tgt[i]) - int'(applied[i]);
				base[i] = applied[i];
				goal[i] = tgt[i];
				if (diff > 0) begin
					dir[i] = SG_UP;
					ramp_len = PULSE_W'(diff / SPRG_STEP);
				end else if (diff < 0) begin
					dir[i] = SG_DOWN;
					ramp_len = PULSE_W'(-diff / SPRG_STEP);
				end else begin
					dir[i] = SG_NONE;
				end
			end
			step_no = '0;
			running = 1'b1;
		end else if (running) begin
			if (step_no >= ramp_len) begin
				// final step lands on the targets with no limit check
				for (int i = 0; i < SERVOS; i++)
					if (dir[i] != SG_NONE)
						applied[i] = goal[i];
				running = 1'b0;
				due_pulses.push_back(applied_set(ST_FINAL));
			end else begin
				out_of_range = 1'b0;
				for (int i = 0; i < SERVOS; i++) begin
					case (dir[i])
						SG_UP: next[i] = longint'(base[i]) + longint'(step_no) * SPRG_STEP;
						SG_DOWN: next[i] = longint'(base[i]) - longint'(step_no) * SPRG_STEP;
						default: next[i] = longint'(base[i]);
					endcase
					if (next[i] < 0 || next[i] > longint'({PULSE_W{1'b1}}) ||
							next[i] < longint'(lim_lo[i]) || next[i] > longint'(lim_hi[i]))
						out_of_range = 1'b1;
				end
				if (out_of_range) begin
					running = 1'b0;
					due_pulses.push_back(applied_set(ST_ABORT));
				end else begin
					for (int i = 0; i < SERVOS; i++)
						applied[i] = next[i][PULSE_W-1:0];
					step_no = step_no + PULSE_W'(1);
					due_pulses.push_back(applied_set(ST_STEP));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		pulse_set_t                     want;
		logic [SERVOS-1:0][PULSE_W-1:0] got;
		if (!arst_n) begin
			for (int i = 0; i < SERVOS; i++) begin
				lim_lo[i] = RST_MIN;
				lim_hi[i] = RST_MAX;
				applied[i] = RST_PULSE;
				base[i] = '0;
				goal[i] = '0;
				dir[i] = SG_NONE;
			end
			ramp_len = '0;
			step_no = '0;
			running = 1'b0;
			due_pulses.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {pulse_s3, pulse_s2, pulse_s1, pulse_s0};
				if (due_pulses.size() == 0) begin
					$error("unexpected result: pulses %0d %0d %0d %0d, status %0d",
						pulse_s0, pulse_s1, pulse_s2, pulse_s3, status);
					mismatches++;
				end else begin
					want = due_pulses.pop_front();
					for (int i = 0; i < SERVOS; i++)
						if (got[i] !== want.pulse[i]) begin
							$error("pulse_s%0d: expected %0d, actual %0d",
								i, want.pulse[i], got[i]);
							mismatches++;
						end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				follow_request(op == 1'(OP_TICK), {target_s3, target_s2, target_s1, target_s0});
			if (cfg_we) begin
				if (cfg_addr[0])
					lim_hi[cfg_addr[2:1]] = cfg_wdata;
				else
					lim_lo[cfg_addr[2:1]] = cfg_wdata;
			end
			pending = due_pulses.size();
		end
	end

endmodule

>>> test/servo_pulse_ramp_generator_core_test.sv
// testbench top for the servo pulse ramp generator: clock, reset, limits and stimulus
`timescale 1ns / 1ps

module servo_pulse_ramp_generator_core_test;
	import sprg_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_addr;
	logic [PULSE_W-1:0] cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic               op;
	logic [PULSE_W-1:0] target_s0;
	logic [PULSE_W-1:0] target_s1;
	logic [PULSE_W-1:0] target_s2;
	logic [PULSE_W-1:0] target_s3;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PULSE_W-1:0] pulse_s0;
	logic [PULSE_W-1:0] pulse_s1;
	logic [PULSE_W-1:0] pulse_s2;
	logic [PULSE_W-1:0] pulse_s3;
	logic [1:0]         status;
	int                 mismatches;
	int                 pending;

	bit                 steady = 1'b0;
	int                 idle_cycles = 0;
	logic [PULSE_W-1:0] cur_lo [SERVOS];
	logic [PULSE_W-1:0] cur_hi [SERVOS];
	int                 last_goal [SERVOS];

	servo_pulse_ramp_generator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.target_s0 (target_s0),
		.target_s1 (target_s1),
		.target_s2 (target_s2),
		.target_s3 (target_s3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pulse_s0  (pulse_s0),
		.pulse_s1  (pulse_s1),
		.pulse_s2  (pulse_s2),
		.pulse_s3  (pulse_s3),
		.status    (status)
	);

	servo_pulse_ramp_generator_core_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.target_s0  (target_s0),
		.target_s1  (target_s1),
		.target_s2  (target_s2),
		.target_s3  (target_s3),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pulse_s0   (pulse_s0),
		.pulse_s1   (pulse_s1),
		.pulse_s2   (pulse_s2),
		.pulse_s3   (pulse_s3),
		.status     (status),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 31);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("servo_pulse_ramp_generator_core verification failed");
			$finish;
		end
	end

	function automatic logic [SERVOS-1:0][PULSE_W-1:0] pulses(input logic [PULSE_W-1:0] p0,
			input logic [PULSE_W-1:0] p1, input logic [PULSE_W-1:0] p2,
			input logic [PULSE_W-1:0] p3);
		return {p3, p2, p1, p0};
	endfunction

	task automatic send_item(input logic is_tick, input logic [SERVOS-1:0][PULSE_W-1:0] tgt);
		while (!steady && $urandom_range(0, 99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= is_tick ? 1'(OP_TICK) : 1'(OP_TARGET);
		target_s0 <= tgt[0];
		target_s1 <= tgt[1];
		target_s2 <= tgt[2];
		target_s3 <= tgt[3];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_tick();
		send_item(1'b1, {$urandom, $urandom});
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [SERVOS-1:0][PULSE_W-1:0] lo,
			input logic [SERVOS-1:0][PULSE_W-1:0] hi);
		for (int i = 0; i < SERVOS; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= 3'(REG_MIN_S0 + 2 * i);
			cfg_wdata <= lo[i];
			@(posedge clk);
			cfg_addr <= 3'(REG_MAX_S0 + 2 * i);
			cfg_wdata <= hi[i];
			@(posedge clk);
			cur_lo[i] = lo[i];
			cur_hi[i] = hi[i];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int count, input int pause_at);
		int                             n;
		int                             v;
		int                             d;
		int                             len_est;
		int                             ticks;
		int                             lo_w [SERVOS];
		int                             hi_w [SERVOS];
		bit                             noise;
		bit                             whole;
		logic [SERVOS-1:0][PULSE_W-1:0] t;
		n = 0;
		for (int i = 0; i < SERVOS; i++) begin
			lo_w[i] = (cur_lo[i] <= cur_hi[i]) ? int'(cur_lo[i]) : int'(cur_hi[i]);
			hi_w[i] = (cur_lo[i] <= cur_hi[i]) ? int'(cur_hi[i]) : int'(cur_lo[i]);
			if (hi_w[i] - lo_w[i] > 3000) begin
				lo_w[i] = 500;
				hi_w[i] = 3500;
			end
			lo_w[i] = (lo_w[i] > 100) ? lo_w[i] - 100 : 0;
			hi_w[i] = (hi_w[i] < 65435) ? hi_w[i] + 100 : 65535;
		end
		while (n < count) begin
			noise = ($urandom_range(0, 9) == 0);
			len_est = 0;
			for (int i = 0; i < SERVOS; i++) begin
				if (noise) begin
					v = $urandom_range(0, 65535);
				end else if ($urandom_range(0, 4) == 0) begin
					v = last_goal[i];
				end else begin
					v = last_goal[i] + int'($urandom_range(0, 640)) - 320;
					if (v < lo_w[i])
						v = lo_w[i];
					if (v > hi_w[i])
						v = hi_w[i];
				end
				t[i] = v[PULSE_W-1:0];
				d = (v > last_goal[i]) ? v - last_goal[i] : last_goal[i] - v;
				if (d / SPRG_STEP > len_est)
					len_est = d / SPRG_STEP;
			end
			send_item(1'b0, t);
			n++;
			whole = !noise && ($urandom_range(0, 99) >= 15);
			if (noise)
				ticks = $urandom_range(0, 6);
			else if (whole)
				ticks = len_est + 1 + $urandom_range(0, 2);
			else
				ticks = $urandom_range(0, len_est);
			repeat (ticks) begin
				send_tick();
				n++;
			end
			if (whole)
				for (int i = 0; i < SERVOS; i++)
					last_goal[i] = t[i];
			if (pause_at > 0 && n >= pause_at) begin
				drain();
				pause_at = 0;
			end
		end
	endtask

	initial begin
		logic [SERVOS-1:0][PULSE_W-1:0] lo;
		logic [SERVOS-1:0][PULSE_W-1:0] hi;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_MIN_S0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		op <= 1'(OP_TARGET);
		target_s0 <= '0;
		target_s1 <= '0;
		target_s2 <= '0;
		target_s3 <= '0;
		for (int i = 0; i < SERVOS; i++) begin
			cur_lo[i] = RST_MIN;
			cur_hi[i] = RST_MAX;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: idle tick, standstill, short ramp, restart mid-ramp, extremes
		send_tick();
		send_item(1'b0, pulses(16'd1500, 16'd1500, 16'd1500, 16'd1500));
		send_tick();
		send_tick();
		send_item(1'b0, pulses(16'd1550, 16'd1460, 16'd1500, 16'd1532));
		repeat (3) send_tick();
		send_item(1'b0, pulses(16'd1600, 16'd1460, 16'd1500, 16'd1532));
		repeat (2) send_tick();
		send_item(1'b0, pulses(16'd0, 16'hFFFF, 16'd0, 16'hFFFF));
		repeat (2) send_tick();
		send_item(1'b0, pulses(16'd1550, 16'd1476, 16'd1484, 16'd1548));
		send_tick();
		drain();

		// servo one with inverted limits: abort on the first step, unchecked final jump
		lo = pulses(RST_MIN, RST_MAX, RST_MIN, RST_MIN);
		hi = pulses(RST_MAX, RST_MIN, RST_MAX, RST_MAX);
		set_limits(lo, hi);
		send_item(1'b0, pulses(16'd1600, 16'd1476, 16'd1484, 16'd1548));
		send_tick();
		send_tick();
		send_item(1'b0, pulses(16'd1550, 16'd1476, 16'd1484, 16'd1555));
		send_tick();
		last_goal = '{1550, 1476, 1484, 1555};
		run_random(60, 0);
		drain();

		// full range limits, first half without any idling
		lo = '0;
		hi = '1;
		set_limits(lo, hi);
		steady = 1'b1;
		run_random(80, 0);
		steady = 1'b0;
		run_random(80, 0);
		drain();

		for (int i = 0; i < SERVOS; i++) begin
			lo[i] = PULSE_W'($urandom_range(500, 1500));
			hi[i] = PULSE_W'(lo[i] + $urandom_range(100, 1500));
		end
		set_limits(lo, hi);
		run_random(160, 80);
		drain();

		// min equal to max
		for (int i = 0; i < SERVOS; i++) begin
			lo[i] = PULSE_W'($urandom_range(1400, 1600));
			hi[i] = lo[i];
		end
		set_limits(lo, hi);
		run_random(60, 0);
		drain();

		lo = pulses(RST_MIN, RST_MIN, RST_MIN, RST_MIN);
		hi = pulses(RST_MAX, RST_MAX, RST_MAX, RST_MAX);
		set_limits(lo, hi);
		run_random(200, 0);
		drain();

		for (int i = 0; i < SERVOS; i++) begin
			lo[i] = PULSE_W'($urandom_range(600, 1400));
			hi[i] = PULSE_W'(lo[i] + $urandom_range(200, 1200));
		end
		lo[2] = 16'd2200;
		hi[2] = 16'd1200;
		set_limits(lo, hi);
		run_random(160, 0);

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("servo_pulse_ramp_generator_core verification clean");
		else
			$display("servo_pulse_ramp_generator_core verification failed");
		$finish;
	end

endmodule

>>> sim.f
sv/sprg_pkg.sv
sv/servo_pulse_ramp_generator_core.sv
test/servo_pulse_ramp_generator_core_check.sv
test/servo_pulse_ramp_generator_core_test.sv
